@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the replacement engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASRT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASRT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/salru_pkg.sv @@
// ----------------------------------------------------------------------------
// salru_pkg
// types and constants of the set-associative lru replacement engine
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int SET_IN_W  = 10;  // width of the set index field
  localparam int WAY_IN_W  = 3;   // width of the way index field
  localparam int MASK_W    = 8;   // ways covered by the valid mask
  localparam int VICTIM_W  = 3;   // width of the returned way

  localparam int WAYS_DEF  = 8;
  localparam int SETS_DEF  = 1024;

  typedef enum logic [0:0] {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [SET_IN_W-1:0]   set_index;
    logic [WAY_IN_W-1:0]   way_index;
    logic [MASK_W-1:0]     valid_mask;
    logic                  is_writeback;
    logic                  was_hit;
  } req_t;

  typedef struct packed {
    logic [VICTIM_W-1:0]   victim_way;
    logic                  no_victim;
  } rsp_t;

endpackage

@@ src/salru_req_if.sv @@
// ----------------------------------------------------------------------------
// salru_req_if
// request channel: valid/ready handshake with a request payload
// ----------------------------------------------------------------------------
interface salru_req_if;
  logic              valid;
  logic              ready;
  salru_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/salru_rsp_if.sv @@
// ----------------------------------------------------------------------------
// salru_rsp_if
// response channel: valid/ready handshake with a victim payload
// ----------------------------------------------------------------------------
interface salru_rsp_if;
  logic              valid;
  logic              ready;
  salru_pkg::rsp_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/salru_row_logic.sv @@
// ----------------------------------------------------------------------------
// salru_row_logic
// victim search and recency update on one set's rank row
// ----------------------------------------------------------------------------
module salru_row_logic #(
  parameter int WAYS   = salru_pkg::WAYS_DEF,
  parameter int RANK_W = $clog2(WAYS)
) (
  input  logic [WAYS-1:0][RANK_W-1:0] row_i,
  input  salru_pkg::req_t             req_i,
  output salru_pkg::rsp_t             rsp_o,
  output logic [WAYS-1:0][RANK_W-1:0] row_o,
  output logic                        we_o
);

  logic              found;
  logic              way_vld;
  logic              in_range;
  logic [RANK_W-1:0] tgt;
  logic [RANK_W-1:0] old_rank;

  // lowest invalid way first, then the oldest way
  always_comb begin
    found = 1'b0;
    way_vld = 1'b1;
    rsp_o = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (w < salru_pkg::MASK_W) begin
        way_vld = req_i.valid_mask[w[2:0]];
      end else begin
        way_vld = 1'b1;
      end
      if (!found && !way_vld) begin
        found = 1'b1;
        rsp_o.victim_way = salru_pkg::VICTIM_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!found && row_i[w] == RANK_W'(WAYS - 1)) begin
        found = 1'b1;
        rsp_o.victim_way = salru_pkg::VICTIM_W'(w);
      end
    end
    rsp_o.no_victim = !found;
  end

  // move target to rank 0 and age every more recent way
  always_comb begin
    in_range = int'(req_i.way_index) < WAYS;
    tgt = RANK_W'(req_i.way_index);
    old_rank = row_i[tgt];
    for (int w = 0; w < WAYS; w++) begin
      if (RANK_W'(w) == tgt) begin
        row_o[w] = '0;
      end else if (row_i[w] < old_rank) begin
        row_o[w] = row_i[w] + RANK_W'(1);
      end else begin
        row_o[w] = row_i[w];
      end
    end
    we_o = (req_i.opcode == salru_pkg::OP_UPDATE) && in_range &&
           !(req_i.is_writeback && req_i.was_hit);
  end

endmodule

@@ src/set_assoc_lru_replacement.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_replacement
// true-lru replacement engine holding one rank row per cache set
// ----------------------------------------------------------------------------
// usage
//   req_i carries victim and update requests; rsp_o returns one transaction
//   per victim request (victim_way, no_victim) and nothing for an update
//   a request is read and then evaluated: the accept cycle reads the set's
//   rank row from the rank memory, the next cycle evaluates it, writes the
//   updated row back and loads the response register
//   no new request is taken until the current one has finished: req_i is
//   ready only in the idle state
//   a victim response is registered and drives rsp_o from the response register
//   while the response register still holds an untaken transaction and a
//   new victim request is ready to finish, that request waits in the
//   evaluate cycle; update requests never wait on rsp_o
//   after reset a clearing pass writes the initial ranks (rank equals way
//   number) into every set, one set per cycle; req_i is not ready during
//   that pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_lru_replacement #(
  parameter int WAYS = salru_pkg::WAYS_DEF,
  parameter int SETS = salru_pkg::SETS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  salru_req_if.sink    req_i,
  salru_rsp_if.source  rsp_o
);

  localparam int RANK_W = $clog2(WAYS);
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int REM_W  = salru_pkg::SET_IN_W + 1;

  typedef logic [WAYS-1:0][RANK_W-1:0] row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_e;

  state_e           state_q;
  logic [SET_W-1:0] clr_idx_q;
  logic [SET_W-1:0] set_q;
  salru_pkg::req_t  req_q;
  salru_pkg::rsp_t  rsp_q;
  logic             rsp_vld_q;

  row_t             rank_mem_q [SETS];
  row_t             rd_q;
  row_t             init_row;
  row_t             upd_row;
  logic             upd_we;
  salru_pkg::rsp_t  eval_rsp;

  logic [REM_W-1:0] set_rem;
  logic [SET_W-1:0] set_addr;
  logic             accept;
  logic             busy_go;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  row_t             mem_wdata;

  // set index reduced modulo SETS by shifted compare and subtract
  always_comb begin
    set_rem = REM_W'(req_i.payload.set_index);
    for (int k = salru_pkg::SET_IN_W - 1; k >= 0; k--) begin
      if ((SETS << k) < (1 << salru_pkg::SET_IN_W)) begin
        if (set_rem >= REM_W'(SETS << k)) begin
          set_rem = set_rem - REM_W'(SETS << k);
        end
      end
    end
    set_addr = SET_W'(set_rem);
  end

  // reset contents of one row: rank equals way number
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      init_row[w] = RANK_W'(w);
    end
  end

  salru_row_logic #(
    .WAYS   (WAYS),
    .RANK_W (RANK_W)
  ) u_row (
    .row_i (rd_q),
    .req_i (req_q),
    .rsp_o (eval_rsp),
    .row_o (upd_row),
    .we_o  (upd_we)
  );

  // handshake and write-port control
  assign req_i.ready   = (state_q == ST_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  // a victim needs a free response slot, an update always finishes
  assign busy_go = (state_q == ST_BUSY) &&
                   ((req_q.opcode == salru_pkg::OP_UPDATE) || !rsp_vld_q || rsp_o.ready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = upd_row;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = init_row;
    end else if (busy_go && upd_we) begin
      mem_we = 1'b1;
    end
  end

  // rank memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rank_mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= rank_mem_q[set_addr];
    end
  end

  // sequencer with clearing pass, request latch and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      set_q     <= '0;
      req_q     <= '0;
      rsp_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      // a finishing victim refills the slot, otherwise a taken one empties it
      if (busy_go && req_q.opcode == salru_pkg::OP_VICTIM) begin
        rsp_q     <= eval_rsp;
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_idx_q == SET_W'(SETS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + SET_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_q   <= req_i.payload;
            set_q   <= set_addr;
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (busy_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASRT_NEXT(a_accept_to_busy, clk_i, rst_ni, accept, state_q == ST_BUSY,
             "accepted request did not enter evaluation")
  `ASRT_NEXT(a_victim_responds, clk_i, rst_ni,
             busy_go && req_q.opcode == salru_pkg::OP_VICTIM, rsp_o.valid,
             "finished victim request left no response")
  `ASRT_SAME(a_victim_no_write, clk_i, rst_ni,
             state_q == ST_BUSY && req_q.opcode == salru_pkg::OP_VICTIM, !mem_we,
             "victim request wrote the rank memory")
  `ASRT_NEXT(a_clear_done, clk_i, rst_ni,
             state_q == ST_CLEAR && clr_idx_q == SET_W'(SETS - 1), state_q == ST_IDLE,
             "clearing pass did not end at the last set")

endmodule
